@@ hw/rtl/delimited_frame_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer RTL files.
// No dependencies; include with the bare file name.
`ifndef DELIMITED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define DELIMITED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Antecedent holds -> consequent holds in the same cycle.
`define DFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// Antecedent holds -> consequent holds in the next cycle.
`define DFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define DFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define DFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/dfd_pkg.sv @@
// Shared types and codes for the delimited frame deframer.
// No dependencies.
package dfd_pkg;

   localparam int unsigned LEN_BITS      = 16;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic [1:0] FT_COMMAND  = 2'd0;
   localparam logic [1:0] FT_RESPONSE = 2'd1;
   localparam logic [1:0] FT_DATA     = 2'd2;

   localparam logic [1:0] EV_BODY  = 2'd0;
   localparam logic [1:0] EV_DONE  = 2'd1;
   localparam logic [1:0] EV_ABORT = 2'd2;

   localparam logic [1:0] CC_UNKNOWN = 2'd0;
   localparam logic [1:0] CC_OK      = 2'd1;
   localparam logic [1:0] CC_CAPTURE = 2'd2;
   localparam logic [1:0] CC_TEXT    = 2'd3;

   typedef struct packed {
      logic [1:0]          frame_type;
      logic [1:0]          event_res;
      logic                byte_valid;
      logic [7:0]          data_byte;
      logic [1:0]          command_code;
      logic [LEN_BITS-1:0] data_length;
   } dfd_result_type;

endpackage

@@ hw/rtl/delimited_frame_deframer_unit.sv @@
// Top level of the delimited frame deframer: input register, parser, result queue, registers.
// Depends on dfd_pkg, dfd_csr, dfd_parser and dfd_out_queue.
//
//   Channel   Direction  Ports                                   Moves
//   req       in         req_valid/req_ready, req_rx_byte        one received byte
//   rsp       out        rsp_valid/rsp_ready, rsp_* fields       one frame event
//   csr       in/out     psel, penable, pwrite, paddr, pwdata,   length cap register
//                        prdata, pready
//
// The block takes one word per cycle while req_ready is high; the per-byte state update in the parser sets that rate.
// An accepted byte is held in the input register and parsed from there, and its result is
// written into the result queue, from which it is offered on rsp.
// Reset is synchronous and active high: the parser hunts for a marker and the cap is 4096.
// A two-entry result queue absorbs output stalls; req_ready falls only when the queue
// could not hold the result of the byte already in flight plus one more.
module delimited_frame_deframer_unit #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel: one received serial byte per word.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   // Result channel: zero or one word per received byte.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_frame_type,
   output logic [1:0]                          rsp_event_res,
   output logic                                rsp_byte_valid,
   output logic [7:0]                          rsp_data_byte,
   output logic [1:0]                          rsp_command_code,
   output logic [dfd_pkg::LEN_BITS-1:0]        rsp_data_length,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dfd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dfd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dfd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   import dfd_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff,  in_byte_in;
   logic [LEN_BITS-1:0] max_frame_len;
   logic                res_valid;
   dfd_result_type      res;
   dfd_result_type      rsp_data;
   logic                room;
   logic                req_take;

   // The length cap register. The user must write it only while no word is in flight; the block does not enforce this.
   dfd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .max_frame_len (max_frame_len)
   );

   // Input register. It refills every cycle when the queue has room, so bytes stream
   // back to back without waiting for the previous result to be taken.
   assign req_ready   = room;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take;
   assign in_byte_in  = req_take ? req_rx_byte : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // The parser consumes the registered byte and may produce one result for it.
   dfd_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (in_valid_ff),
      .item_byte     (in_byte_ff),
      .max_frame_len (max_frame_len),
      .res_valid     (res_valid),
      .res           (res)
   );

   // The result queue parts the parser from the output handshake.
   dfd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pending   (in_valid_ff),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_frame_type   = rsp_data.frame_type;
   assign rsp_event_res    = rsp_data.event_res;
   assign rsp_byte_valid   = rsp_data.byte_valid;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_command_code = rsp_data.command_code;
   assign rsp_data_length  = rsp_data.data_length;

endmodule

@@ hw/rtl/dfd_csr.sv @@
// APB-style register file holding the frame length cap.
// Depends on dfd_pkg.
module dfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dfd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dfd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dfd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output logic [dfd_pkg::LEN_BITS-1:0]        max_frame_len
);
   import dfd_pkg::*;

   localparam logic                REG_MAX_FRAME_LEN = 1'b0;
   localparam logic [LEN_BITS-1:0] MAX_FRAME_RESET   = LEN_BITS'(4096);

   logic [LEN_BITS-1:0] max_len_ff;
   logic [LEN_BITS-1:0] max_len_in;
   logic                reg_sel;

   // Registers sit on 4-byte boundaries; the low two address bits are ignored.
   assign reg_sel = paddr[CSR_ADDR_BITS-1:2] == REG_MAX_FRAME_LEN;

   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && reg_sel) begin
         max_len_in = pwdata[LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign pready        = 1'b1;
   assign prdata        = reg_sel ? CSR_DATA_BITS'(max_len_ff) : '0;
   assign max_frame_len = max_len_ff;

endmodule

@@ hw/rtl/dfd_parser.sv @@
// Per-byte frame parser: holds the frame state and forms at most one result per byte.
// Depends on dfd_pkg and the assertion header.
`include "delimited_frame_deframer_unit_assert.svh"
module dfd_parser #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [7:0]                    item_byte,
   input  logic [dfd_pkg::LEN_BITS-1:0]  max_frame_len,
   output logic                          res_valid,
   output dfd_pkg::dfd_result_type       res
);
   import dfd_pkg::*;

   localparam int unsigned ACC_BITS = COUNT_BITS + 4;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [2:0] MODE_HUNT = 3'd0;
   localparam logic [2:0] MODE_CMD  = 3'd1;
   localparam logic [2:0] MODE_RESP = 3'd2;
   localparam logic [2:0] MODE_DLEN = 3'd3;
   localparam logic [2:0] MODE_PAY  = 3'd4;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_K     = 8'h6B;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_T     = 8'h74;

   logic [2:0]            mode_ff,           mode_in;
   logic [LEN_BITS-1:0]   frame_bytes_ff,    frame_bytes_in;
   logic [COUNT_BITS-1:0] length_value_ff,   length_value_in;
   logic                  length_nonempty_ff, length_nonempty_in;
   logic                  digits_ended_ff,   digits_ended_in;
   logic [COUNT_BITS-1:0] payload_left_ff,   payload_left_in;
   logic [1:0]            match_pos_ff,      match_pos_in;
   logic [2:0]            match_alive_ff,    match_alive_in;

   logic                  hunting;
   logic                  fresh;
   logic [2:0]            mode_cur;
   logic [LEN_BITS-1:0]   fb_cur;
   logic [COUNT_BITS-1:0] lv_cur;
   logic [ACC_BITS-1:0]   acc;
   logic [COUNT_BITS-1:0] lv_next;
   logic [COUNT_BITS-1:0] pl_dec;
   logic [1:0]            class_code;
   logic [2:0]            alive_upd;
   logic [7:0]            close_char;
   logic                  frame_clear;
   logic                  abort_out;
   logic                  abort_bare;

   function automatic logic [1:0] type_of_mode(input logic [2:0] m);
      if (m == MODE_CMD) begin
         return FT_COMMAND;
      end else if (m == MODE_RESP) begin
         return FT_RESPONSE;
      end
      return FT_DATA;
   endfunction

   // Saturating decimal accumulate: value * 10 + digit.
   assign acc     = (ACC_BITS'(length_value_ff) << 3) + (ACC_BITS'(length_value_ff) << 1)
                  + ACC_BITS'(item_byte[3:0]);
   assign lv_next = (acc[ACC_BITS-1:COUNT_BITS] != '0) ? COUNT_MAX : acc[COUNT_BITS-1:0];
   assign pl_dec  = (payload_left_ff != '0) ? payload_left_ff - COUNT_BITS'(1) : '0;

   // Classification of the command body seen so far.
   always_comb begin
      if (match_alive_ff[0] && match_pos_ff == 2'd2) begin
         class_code = CC_OK;
      end else if (match_alive_ff[1] && match_pos_ff == 2'd3) begin
         class_code = CC_CAPTURE;
      end else if (match_alive_ff[2] && match_pos_ff == 2'd1) begin
         class_code = CC_TEXT;
      end else begin
         class_code = CC_UNKNOWN;
      end
   end

   // Candidate filter for one more command body byte.
   always_comb begin
      alive_upd = match_alive_ff;
      if (!((match_pos_ff == 2'd0 && item_byte == CH_O) ||
            (match_pos_ff == 2'd1 && item_byte == CH_K))) begin
         alive_upd[0] = 1'b0;
      end
      if (!((match_pos_ff == 2'd0 && item_byte == CH_I) ||
            (match_pos_ff == 2'd1 && item_byte == CH_COLON) ||
            (match_pos_ff == 2'd2 && item_byte == CH_C))) begin
         alive_upd[1] = 1'b0;
      end
      if (!(match_pos_ff == 2'd0 && item_byte == CH_T)) begin
         alive_upd[2] = 1'b0;
      end
   end

   assign hunting    = !(mode_ff inside {MODE_CMD, MODE_RESP, MODE_DLEN, MODE_PAY});
   assign close_char = (mode_ff == MODE_CMD) ? CH_HASH : CH_AT;

   // Marker detection while hunting.
   always_comb begin
      mode_cur = mode_ff;
      fresh    = 1'b0;
      if (hunting) begin
         mode_cur = MODE_HUNT;
         case (item_byte)
            CH_HASH: begin
               mode_cur = MODE_CMD;
               fresh    = 1'b1;
            end
            CH_AT: begin
               mode_cur = MODE_RESP;
               fresh    = 1'b1;
            end
            CH_BANG: begin
               mode_cur = MODE_DLEN;
               fresh    = 1'b1;
            end
            default: begin
               mode_cur = MODE_HUNT;
            end
         endcase
      end
   end

   assign fb_cur = fresh ? '0 : frame_bytes_ff;
   assign lv_cur = fresh ? '0 : length_value_ff;

   always_comb begin
      mode_in            = mode_ff;
      frame_bytes_in     = frame_bytes_ff;
      length_value_in    = length_value_ff;
      length_nonempty_in = length_nonempty_ff;
      digits_ended_in    = digits_ended_ff;
      payload_left_in    = payload_left_ff;
      match_pos_in       = match_pos_ff;
      match_alive_in     = match_alive_ff;
      res_valid          = 1'b0;
      res                = '0;

      if (item_valid && mode_cur != MODE_HUNT) begin
         if (fb_cur >= max_frame_len) begin
            // Length cap reached: abort the frame and go back to hunting.
            res_valid          = 1'b1;
            res.frame_type     = type_of_mode(mode_cur);
            res.event_res      = EV_ABORT;
            res.data_length    = (mode_cur == MODE_DLEN || mode_cur == MODE_PAY) ?
                                 LEN_BITS'(lv_cur) : '0;
            mode_in            = MODE_HUNT;
            frame_bytes_in     = '0;
            length_value_in    = '0;
            length_nonempty_in = 1'b0;
            digits_ended_in    = 1'b0;
            payload_left_in    = '0;
            match_pos_in       = '0;
            match_alive_in     = 3'b111;
         end else if (fresh) begin
            // Opening marker: start a clean frame with the marker counted.
            mode_in            = mode_cur;
            frame_bytes_in     = LEN_BITS'(1);
            length_value_in    = '0;
            length_nonempty_in = 1'b0;
            digits_ended_in    = 1'b0;
            payload_left_in    = '0;
            match_pos_in       = '0;
            match_alive_in     = 3'b111;
         end else begin
            frame_bytes_in = frame_bytes_ff + LEN_BITS'(1);
            case (mode_ff)
               MODE_CMD, MODE_RESP: begin
                  res_valid       = 1'b1;
                  res.frame_type  = type_of_mode(mode_ff);
                  if (item_byte == close_char) begin
                     res.event_res    = EV_DONE;
                     res.command_code = (mode_ff == MODE_CMD) ? class_code : CC_UNKNOWN;
                     mode_in          = MODE_HUNT;
                     frame_bytes_in   = '0;
                     match_pos_in     = '0;
                     match_alive_in   = 3'b111;
                  end else begin
                     res.event_res  = EV_BODY;
                     res.byte_valid = 1'b1;
                     res.data_byte  = item_byte;
                     if (mode_ff == MODE_CMD) begin
                        match_alive_in = alive_upd;
                        match_pos_in   = (match_pos_ff == 2'd3) ? 2'd3 : match_pos_ff + 2'd1;
                     end
                  end
               end
               MODE_DLEN: begin
                  if (item_byte == CH_BANG) begin
                     if (!length_nonempty_ff) begin
                        // Empty length header restarts the data frame here.
                        frame_bytes_in     = LEN_BITS'(1);
                        length_value_in    = '0;
                        digits_ended_in    = 1'b0;
                     end else if (length_value_ff == '0) begin
                        res_valid          = 1'b1;
                        res.frame_type     = FT_DATA;
                        res.event_res      = EV_DONE;
                        mode_in            = MODE_HUNT;
                        frame_bytes_in     = '0;
                        length_value_in    = '0;
                        length_nonempty_in = 1'b0;
                        digits_ended_in    = 1'b0;
                     end else begin
                        payload_left_in = length_value_ff;
                        mode_in         = MODE_PAY;
                     end
                  end else begin
                     length_nonempty_in = 1'b1;
                     if (!digits_ended_ff && (item_byte inside {[CH_ZERO:CH_NINE]})) begin
                        length_value_in = lv_next;
                     end else begin
                        digits_ended_in = 1'b1;
                     end
                  end
               end
               MODE_PAY: begin
                  res_valid       = 1'b1;
                  res.frame_type  = FT_DATA;
                  res.byte_valid  = 1'b1;
                  res.data_byte   = item_byte;
                  res.data_length = LEN_BITS'(length_value_ff);
                  if (pl_dec == '0) begin
                     res.event_res      = EV_DONE;
                     mode_in            = MODE_HUNT;
                     frame_bytes_in     = '0;
                     length_value_in    = '0;
                     length_nonempty_in = 1'b0;
                     digits_ended_in    = 1'b0;
                     payload_left_in    = '0;
                  end else begin
                     res.event_res   = EV_BODY;
                     payload_left_in = pl_dec;
                  end
               end
               default: begin
                  mode_in = MODE_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_HUNT;
         frame_bytes_ff     <= '0;
         length_value_ff    <= '0;
         length_nonempty_ff <= 1'b0;
         digits_ended_ff    <= 1'b0;
         payload_left_ff    <= '0;
         match_pos_ff       <= '0;
         match_alive_ff     <= 3'b111;
      end else begin
         mode_ff            <= mode_in;
         frame_bytes_ff     <= frame_bytes_in;
         length_value_ff    <= length_value_in;
         length_nonempty_ff <= length_nonempty_in;
         digits_ended_ff    <= digits_ended_in;
         payload_left_ff    <= payload_left_in;
         match_pos_ff       <= match_pos_in;
         match_alive_ff     <= match_alive_in;
      end
   end

   assign frame_clear = frame_bytes_ff == '0 && length_value_ff == '0;
   assign abort_out   = res_valid && res.event_res == EV_ABORT;
   assign abort_bare  = !res.byte_valid && res.command_code == CC_UNKNOWN;

   `DFD_ASSERT_IMP(a_pay_has_left, clock, reset, mode_ff == MODE_PAY, payload_left_ff != '0)
   `DFD_ASSERT_IMP(a_hunt_is_clear, clock, reset, mode_ff == MODE_HUNT, frame_clear)
   `DFD_ASSERT_IMP(a_frame_counted, clock, reset, mode_ff != MODE_HUNT, frame_bytes_ff != '0)
   `DFD_ASSERT_IMP(a_abort_is_bare, clock, reset, abort_out, abort_bare)

endmodule

@@ hw/rtl/dfd_out_queue.sv @@
// Two-entry result queue between the parser and the result channel.
// Depends on dfd_pkg and the assertion header.
`include "delimited_frame_deframer_unit_assert.svh"
module dfd_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dfd_pkg::dfd_result_type push_data,
   input  logic                    pending,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dfd_pkg::dfd_result_type rsp_data
);
   import dfd_pkg::*;

   dfd_result_type data_ff [2];
   logic [1:0]     count_ff, count_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           pop;
   logic [2:0]     level;

   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = data_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // A new byte may enter only if the word already in flight still finds a slot.
   assign level = 3'(count_ff) + 3'(pending);
   assign room  = level <= 3'd1 + 3'(pop);

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(pop);
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DFD_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff != 2'd2)
   `DFD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff != 2'd3)
   `DFD_ASSERT_NEXT(a_full_holds, clock, reset, count_ff == 2'd2 && !pop, count_ff == 2'd2)

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the delimited frame deframer: byte stream in, frame events out.
// Depends on dfd_pkg and delimited_frame_deframer_unit; it needs no other file.
// A small scoreboard class predicts every frame event; plain tasks drive the input and register ports.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dfd_pkg::*;

   // Frame markers and the characters that the length header and the flush logic use.
   localparam bit [7:0] MARK_COMMAND  = "#";
   localparam bit [7:0] MARK_RESPONSE = "@";
   localparam bit [7:0] MARK_DATA     = "!";
   localparam bit [7:0] DIGIT_ZERO    = "0";
   localparam bit [7:0] DIGIT_NINE    = "9";

   localparam bit [15:0] RESET_FRAME_CAP = 16'd4096;
   localparam bit [15:0] LENGTH_SATURATED = 16'hFFFF;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_MAX_FRAME_LEN = '0;

   // Settling time that covers the input register and the result queue.
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT      = 600000;
   localparam int          BYTES_PER_PHASE  = 30;

   typedef enum bit [2:0] {
      PM_HUNT,
      PM_COMMAND,
      PM_RESPONSE,
      PM_LENGTH,
      PM_PAYLOAD
   } parse_mode_type;

   // Tracks the parser state for every accepted byte and holds the frame events it must emit.
   class frame_scoreboard_type;
      bit [15:0]      frame_cap;
      parse_mode_type mode;
      bit [15:0]      frame_bytes;
      bit [15:0]      length_value;
      bit [15:0]      payload_left;
      bit             length_nonempty;
      bit             digits_ended;
      bit [1:0]       match_pos;
      bit [2:0]       match_alive;
      dfd_result_type expected_events[$];
      int unsigned    mismatches;
      int unsigned    events_checked;
      int unsigned    aborts;
      int unsigned    frames_done[3];

      function new();
         frame_cap = RESET_FRAME_CAP;
         mode = PM_HUNT;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_bytes = '0;
         length_value = '0;
         length_nonempty = 1'b0;
         digits_ended = 1'b0;
         payload_left = '0;
         match_pos = '0;
         match_alive = 3'b111;
      endfunction

      function logic [1:0] current_type();
         if (mode == PM_COMMAND) return FT_COMMAND;
         if (mode == PM_RESPONSE) return FT_RESPONSE;
         return FT_DATA;
      endfunction

      function void queue_event(logic [1:0] ftype, logic [1:0] ev, logic valid,
                                logic [7:0] data, logic [1:0] code, logic [15:0] dlen);
         dfd_result_type item;
         item.frame_type = ftype;
         item.event_res = ev;
         item.byte_valid = valid;
         item.data_byte = data;
         item.command_code = code;
         item.data_length = dlen;
         expected_events.push_back(item);
      endfunction

      // Three candidates, "ok", "i:c" and "t", are tracked one body byte at a time.
      function void match_command_byte(bit [7:0] b);
         if (!(match_pos == 0 && b == "o") && !(match_pos == 1 && b == "k"))
            match_alive[0] = 1'b0;
         if (!(match_pos == 0 && b == "i") && !(match_pos == 1 && b == ":") &&
             !(match_pos == 2 && b == "c"))
            match_alive[1] = 1'b0;
         if (!(match_pos == 0 && b == "t"))
            match_alive[2] = 1'b0;
         if (match_pos < 3) match_pos++;
      endfunction

      function logic [1:0] command_class();
         if (match_alive[0] && match_pos == 2) return CC_OK;
         if (match_alive[1] && match_pos == 3) return CC_CAPTURE;
         if (match_alive[2] && match_pos == 1) return CC_TEXT;
         return CC_UNKNOWN;
      endfunction

      // Advances the parser by one accepted byte and queues the event it causes, if any.
      function void note_byte(bit [7:0] b);
         bit [20:0] acc;
         bit [7:0]  closer;
         if (mode == PM_HUNT) begin
            if (b == MARK_COMMAND) mode = PM_COMMAND;
            else if (b == MARK_RESPONSE) mode = PM_RESPONSE;
            else if (b == MARK_DATA) mode = PM_LENGTH;
            else return;
            clear_frame();
         end
         // The cap is checked before the byte is interpreted, the opening marker included.
         if ({1'b0, frame_bytes} + 17'd1 > {1'b0, frame_cap}) begin
            queue_event(current_type(), EV_ABORT, 1'b0, 8'd0, CC_UNKNOWN,
                        (mode == PM_LENGTH || mode == PM_PAYLOAD) ? length_value : 16'd0);
            mode = PM_HUNT;
            clear_frame();
            return;
         end
         frame_bytes++;
         if (frame_bytes == 16'd1) return;
         case (mode)
            PM_COMMAND, PM_RESPONSE: begin
               closer = (mode == PM_COMMAND) ? MARK_COMMAND : MARK_RESPONSE;
               if (b == closer) begin
                  queue_event(current_type(), EV_DONE, 1'b0, 8'd0,
                              (mode == PM_COMMAND) ? command_class() : CC_UNKNOWN, 16'd0);
                  mode = PM_HUNT;
                  clear_frame();
               end else begin
                  if (mode == PM_COMMAND) match_command_byte(b);
                  queue_event(current_type(), EV_BODY, 1'b1, b, CC_UNKNOWN, 16'd0);
               end
            end
            PM_LENGTH: begin
               if (b == MARK_DATA) begin
                  if (!length_nonempty) begin
                     // An empty header restarts the frame at this marker.
                     clear_frame();
                     frame_bytes = 16'd1;
                  end else if (length_value == 16'd0) begin
                     queue_event(FT_DATA, EV_DONE, 1'b0, 8'd0, CC_UNKNOWN, 16'd0);
                     mode = PM_HUNT;
                     clear_frame();
                  end else begin
                     payload_left = length_value;
                     mode = PM_PAYLOAD;
                  end
               end else begin
                  length_nonempty = 1'b1;
                  if (!digits_ended && b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
                     acc = 21'(length_value) * 21'd10 + 21'(b - DIGIT_ZERO);
                     length_value = (acc > 21'(LENGTH_SATURATED)) ? LENGTH_SATURATED
                                                                  : acc[15:0];
                  end else begin
                     digits_ended = 1'b1;
                  end
               end
            end
            default: begin
               if (payload_left > 0) payload_left--;
               if (payload_left == 0) begin
                  queue_event(FT_DATA, EV_DONE, 1'b1, b, CC_UNKNOWN, length_value);
                  mode = PM_HUNT;
                  clear_frame();
               end else begin
                  queue_event(FT_DATA, EV_BODY, 1'b1, b, CC_UNKNOWN, length_value);
               end
            end
         endcase
      endfunction

      // A byte that moves the parser toward the end of the frame it is in.
      function bit [7:0] byte_to_close();
         case (mode)
            PM_COMMAND:  return MARK_COMMAND;
            PM_RESPONSE: return MARK_RESPONSE;
            PM_LENGTH:   return length_nonempty ? MARK_DATA : DIGIT_ZERO;
            default:     return 8'($urandom_range(0, 255));
         endcase
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(dfd_result_type got);
         dfd_result_type want;
         if (expected_events.size() == 0) begin
            $error("unexpected frame event: type %0d, event %0d, byte %0d",
                   got.frame_type, got.event_res, got.data_byte);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         events_checked++;
         compare_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
         compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
         compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
         compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
         compare_field("command_code", 16'(want.command_code), 16'(got.command_code));
         compare_field("data_length", want.data_length, got.data_length);
         if (want.event_res == EV_ABORT) aborts++;
         else if (want.event_res == EV_DONE) frames_done[want.frame_type]++;
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [7:0]               req_rx_byte;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_frame_type;
   logic [1:0]               rsp_event_res;
   logic                     rsp_byte_valid;
   logic [7:0]               rsp_data_byte;
   logic [1:0]               rsp_command_code;
   logic [LEN_BITS-1:0]      rsp_data_length;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   frame_scoreboard_type scoreboard = new();

   bit [7:0]    byte_plan[$];
   bit          idling_on = 1'b1;
   bit          hold_off_request = 1'b0;
   bit          req_offered = 1'b0;
   int unsigned bytes_sent;
   int unsigned caps_programmed;
   int unsigned cycles_run;

   delimited_frame_deframer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_event_res    (rsp_event_res),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_command_code (rsp_command_code),
      .rsp_data_length  (rsp_data_length),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Every process samples at the rising edge, so it sees the values from before that edge's
   // register updates; all drives are nonblocking and land after that.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         scoreboard.check_event(dfd_result_type'({rsp_frame_type, rsp_event_res,
                                                  rsp_byte_valid, rsp_data_byte,
                                                  rsp_command_code, rsp_data_length}));
      end
   end

   // The receiver. It stalls in short random bursts while idling is on, and once, on
   // request, holds off for a long stretch that it counts itself, so that the result queue
   // fills and the block has to stall its input.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // Offers one word and holds it until the block takes it; the scoreboard learns of the byte
   // at the edge that accepts it. The valid stays high into the next word unless a gap follows.
   task automatic send_byte(input bit [7:0] value);
      req_valid <= 1'b1;
      req_rx_byte <= value;
      req_offered = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      scoreboard.note_byte(value);
      bytes_sent++;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_plan();
      while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
   endtask

   // Drops valid, waits for every predicted event, then lets bytes that cause no event
   // finish their trip through the pipeline.
   task automatic wait_idle();
      if (req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (scoreboard.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: a setup phase, an access phase, then an idle phase so that the next
   // transfer never lowers and raises psel at the same edge.
   task automatic csr_access(input bit write, input bit [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= ADDR_MAX_FRAME_LEN;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!(psel && penable && pready));
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_frame_cap(input bit [15:0] cap);
      logic [31:0] readback;
      csr_access(1'b0, 32'd0, readback);
      if (readback[15:0] !== cap) begin
         $error("max_frame_len mismatch: expected %0d, got %0d", cap, readback[15:0]);
         scoreboard.mismatches++;
      end
   endtask

   // The upper half of the write data is random; only the low 16 bits form the cap.
   task automatic program_frame_cap(input bit [15:0] cap);
      logic [31:0] unused_read;
      csr_access(1'b1, {16'($urandom), cap}, unused_read);
      scoreboard.frame_cap = cap;
      caps_programmed++;
      check_frame_cap(cap);
   endtask

   function automatic void push_text(string text);
      for (int i = 0; i < text.len(); i++) byte_plan.push_back(text[i]);
   endfunction

   function automatic bit [7:0] random_byte_except(bit [7:0] avoid);
      bit [7:0] value;
      do value = 8'($urandom_range(0, 255)); while (value == avoid);
      return value;
   endfunction

   // Command bodies lean toward the three known commands and their near misses, so the
   // matcher sees partial and overlong hits as well as random text.
   function automatic void add_command_frame();
      string       near_miss[8] = '{"o", "k", "i:", "i:cx", "okk", "tt", "ko", "ti:c"};
      string       alphabet = "oki:ct";
      int unsigned pick;
      byte_plan.push_back(MARK_COMMAND);
      pick = $urandom_range(0, 7);
      case (pick)
         0: push_text("ok");
         1: push_text("i:c");
         2: push_text("t");
         3: push_text(near_miss[$urandom_range(0, 7)]);
         4, 5: repeat ($urandom_range(0, 4)) byte_plan.push_back(alphabet[$urandom_range(0, 5)]);
         default: repeat ($urandom_range(0, 10))
            byte_plan.push_back(random_byte_except(MARK_COMMAND));
      endcase
      byte_plan.push_back(MARK_COMMAND);
   endfunction

   function automatic void add_response_frame();
      byte_plan.push_back(MARK_RESPONSE);
      repeat ($urandom_range(0, 10)) byte_plan.push_back(random_byte_except(MARK_RESPONSE));
      byte_plan.push_back(MARK_RESPONSE);
   endfunction

   // Lengths are mostly short. A saturating header only appears under a small cap, which
   // then aborts the frame long before its payload would end.
   function automatic void add_data_frame(bit [15:0] cap);
      int unsigned pick;
      int unsigned count;
      string       header;
      pick = $urandom_range(0, 15);
      if (pick < 10) count = $urandom_range(0, 12);
      else if (pick < 14) count = $urandom_range(13, 60);
      else if (cap <= 300) count = LENGTH_SATURATED;
      else count = $urandom_range(61, 150);
      header = (count == LENGTH_SATURATED) ? "99999" : $sformatf("%0d", count);
      if ($urandom_range(0, 9) == 0) header = {"00", header};
      if ($urandom_range(0, 5) == 0) header = {header, "x7?"};
      if ($urandom_range(0, 11) == 0) begin
         // A header with no digit at all declares length zero.
         header = "z";
         count = 0;
      end
      byte_plan.push_back(MARK_DATA);
      if ($urandom_range(0, 7) == 0) byte_plan.push_back(MARK_DATA);
      push_text(header);
      byte_plan.push_back(MARK_DATA);
      if (count > cap) count = cap + 1;
      repeat (count) byte_plan.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_noise();
      bit [7:0] value;
      repeat ($urandom_range(1, 4)) begin
         do value = 8'($urandom_range(0, 255));
         while ($urandom_range(0, 3) != 0 &&
                (value == MARK_COMMAND || value == MARK_RESPONSE || value == MARK_DATA));
         byte_plan.push_back(value);
      end
   endfunction

   // One setting of the cap: bring the parser back to hunting, reprogram the cap while the
   // block is idle, hit the cap boundary on purpose, then stream random frames.
   task automatic run_phase(input bit [15:0] cap, input int goal);
      int          remaining;
      int unsigned kind;
      int unsigned drop;
      remaining = goal;
      while (scoreboard.mode != PM_HUNT) send_byte(scoreboard.byte_to_close());
      wait_idle();
      program_frame_cap(cap);
      if (cap >= 2 && cap <= 40) begin
         // A command that ends exactly at the cap, then one whose closing marker is past it.
         byte_plan.push_back(MARK_COMMAND);
         repeat (cap - 2) byte_plan.push_back(random_byte_except(MARK_COMMAND));
         byte_plan.push_back(MARK_COMMAND);
         byte_plan.push_back(MARK_COMMAND);
         repeat (cap - 1) byte_plan.push_back(random_byte_except(MARK_COMMAND));
         byte_plan.push_back(MARK_COMMAND);
      end
      if (cap >= 8 && cap <= 300) begin
         // A length that saturates, aborted in its payload while carrying the full value.
         push_text("!70000!");
         repeat (cap - 6) byte_plan.push_back(8'($urandom_range(0, 255)));
      end
      send_plan();
      if (cap == LENGTH_SATURATED) hold_off_request = 1'b1;
      while (remaining > 0) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) add_command_frame();
         else if (kind <= 4) add_response_frame();
         else if (kind <= 7) add_data_frame(cap);
         else if (kind == 8) add_noise();
         else begin
            // A frame cut short, so the next one lands inside it.
            if ($urandom_range(0, 1) == 0) add_command_frame();
            else add_data_frame(cap);
            drop = $urandom_range(1, 3);
            while (drop > 0 && byte_plan.size() > 1) begin
               void'(byte_plan.pop_back());
               drop--;
            end
         end
         if (kind != 8) remaining -= int'(byte_plan.size());
         send_plan();
      end
   endtask

   initial begin
      bit [15:0] frame_caps[8];
      frame_caps = '{16'd65535, 16'd1, 16'd3, 16'd12, 16'd40, 16'd100, 16'd0,
                     RESET_FRAME_CAP};
      frame_caps[6] = 16'($urandom_range(2, 120));

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_frame_cap(RESET_FRAME_CAP);

      // Directed opening under the reset cap: the byte extremes dropped while hunting, all
      // four command classes, a response holding another marker, an empty length header
      // that restarts the frame, digits ended by junk before a one-byte payload, a zero length,
      // and a two-byte payload made of markers that only count as payload.
      byte_plan.push_back(8'h00);
      byte_plan.push_back(8'hFF);
      push_text("#ok##i:c##t###@#@!!1x9!");
      byte_plan.push_back(8'hFF);
      push_text("!0!!2!#@");
      send_plan();

      foreach (frame_caps[i]) begin
         // The last setting runs with no idling on either side.
         if (i == 7) idling_on = 1'b0;
         run_phase(frame_caps[i], BYTES_PER_PHASE);
      end
      wait_idle();

      $display("summary: %0d bytes sent under %0d cap settings, %0d frame events checked",
               bytes_sent, caps_programmed, scoreboard.events_checked);
      $display("summary: %0d command, %0d response, %0d data frames done, %0d aborted",
               scoreboard.frames_done[FT_COMMAND], scoreboard.frames_done[FT_RESPONSE],
               scoreboard.frames_done[FT_DATA], scoreboard.aborts);
      if (scoreboard.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ delimited_frame_deframer_unit.f @@
+incdir+hw/rtl
hw/rtl/dfd_pkg.sv
hw/rtl/dfd_csr.sv
hw/rtl/dfd_parser.sv
hw/rtl/dfd_out_queue.sv
hw/rtl/delimited_frame_deframer_unit.sv
test/testbench.sv
